[rtl/lzw12_pkg.sv]
// Shared types and constants for the 12-bit LZW encoder.
package lzw12_pkg;

   localparam int BYTE_W          = 8;
   localparam int FIRST_FREE_CODE = 256;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_PROBE  = 4'b0100,
      ST_VERIFY = 4'b1000
   } state_type;

endpackage

[rtl/lzw_encoder_12bit_top.sv]
// Top level of the LZW encoder: hashed dictionary lookup, code assignment and output buffer.
//
// Usage
//   req_* : one raw byte per word; req_tlast marks the final byte of a stream.
//   rsp_* : one emitted code per word; rsp_tlast is set on the code flushed by
//           the final byte. A byte causes zero, one or two codes.
// Lookup
//   A byte that opens a stream needs no lookup. Any other byte is looked up in a
//   linear-probed hash table: a miss at an empty slot ends after the hash RAM read;
//   a hit, or a slot left over from an earlier stream, also needs a read of the
//   code's pair and home slot, and every colliding slot adds a further probe. The
//   current stream holds at most half of the slots, so probes are short. Codes are
//   registered in the output buffer before they reach rsp_tdata.
// Reset
//   After reset all 2 * 2**clog2(DICT_SIZE) hash slots (8192 at the default) are
//   swept to zero, one slot per cycle, with req_tready low.
//   A stream end needs no sweep: a slot whose code is not below the next free code,
//   or whose code's pair was filed under another slot, reads as empty.
// Stalls
//   Codes wait in a two-word output buffer; lookups pause while it lacks room, and
//   req_tready drops while it is full.
module lzw_encoder_12bit_top
   import lzw12_pkg::*;
#(
   parameter int DICT_SIZE = 4096,
   localparam int CODE_W = $clog2(DICT_SIZE),
   localparam int RSP_W  = ((CODE_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // end_of_input
   // output words
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,   // [CODE_W-1:0] code, zero filled above
   output logic              rsp_tlast    // final_code
);

   localparam int HASH_W     = CODE_W + 1;
   localparam int HASH_DEPTH = 2 ** HASH_W;
   localparam int NF_W       = $clog2(DICT_SIZE + 1);
   localparam int KEY_W      = CODE_W + BYTE_W;
   localparam int PAIR_W     = HASH_W + KEY_W;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              final_code;
   } out_word_type;

   // hash of a (prefix, byte) pair into a slot of the probe table
   function automatic logic [HASH_W-1:0] hash_key(input logic [CODE_W-1:0] p,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] bx;
      bx = HASH_W'(b);
      return {p, 1'b0} ^ bx ^ (bx << (HASH_W - BYTE_W));
   endfunction

   state_type         state_ff, state_in;
   logic [HASH_W-1:0] clr_ff, clr_in;
   logic [CODE_W-1:0] prefix_ff, prefix_in;
   logic              pvalid_ff, pvalid_in;
   logic [NF_W-1:0]   nf_ff, nf_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic [HASH_W-1:0] slot_ff, slot_in;
   logic [CODE_W-1:0] cand_ff, cand_in;
   out_word_type      q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]        cnt_ff, cnt_in;

   // memory ports
   logic              hash_wr_en, hash_rd_en;
   logic [HASH_W-1:0] hash_wr_addr, hash_rd_addr;
   logic [CODE_W-1:0] hash_wr_data, hash_rd_data;
   logic              pair_wr_en, pair_rd_en;
   logic [CODE_W-1:0] pair_wr_addr, pair_rd_addr;
   logic [PAIR_W-1:0] pair_wr_data, pair_rd_data;

   // result pushes decided this cycle
   logic              push_a, push_b;
   out_word_type      word_a, word_b;

   logic              req_fire, rsp_fire;
   logic [1:0]        room;
   logic [KEY_W-1:0]  key;
   logic              slot_used;
   logic              table_open;
   logic              do_miss;
   logic [KEY_W-1:0]  pair_rd_key;
   logic [HASH_W-1:0] pair_rd_slot;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && (cnt_ff != 2'd2);
   assign room       = 2'd2 - cnt_ff;
   assign key        = {prefix_ff, byte_ff};
   assign table_open = nf_ff < NF_W'(DICT_SIZE);
   // slot holds a code at or above the first free code and below the next free code
   assign slot_used  = (hash_rd_data >= CODE_W'(FIRST_FREE_CODE))
                       && (NF_W'(hash_rd_data) < nf_ff);
   // pair entry: home slot above the (prefix, byte) key
   assign pair_rd_key  = pair_rd_data[KEY_W-1:0];
   assign pair_rd_slot = pair_rd_data[PAIR_W-1:KEY_W];

   lzw12_ram #(.WIDTH(CODE_W), .DEPTH(HASH_DEPTH)) u_hash_ram (
      .clock   (clock),
      .wr_en   (hash_wr_en),
      .wr_addr (hash_wr_addr),
      .wr_data (hash_wr_data),
      .rd_en   (hash_rd_en),
      .rd_addr (hash_rd_addr),
      .rd_data (hash_rd_data)
   );

   lzw12_ram #(.WIDTH(PAIR_W), .DEPTH(DICT_SIZE)) u_pair_ram (
      .clock   (clock),
      .wr_en   (pair_wr_en),
      .wr_addr (pair_wr_addr),
      .wr_data (pair_wr_data),
      .rd_en   (pair_rd_en),
      .rd_addr (pair_rd_addr),
      .rd_data (pair_rd_data)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      prefix_in = prefix_ff;
      pvalid_in = pvalid_ff;
      nf_in     = nf_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      slot_in   = slot_ff;
      cand_in   = cand_ff;
      do_miss   = 1'b0;

      hash_wr_en   = 1'b0;
      hash_wr_addr = slot_ff;
      hash_wr_data = nf_ff[CODE_W-1:0];
      hash_rd_en   = 1'b0;
      hash_rd_addr = slot_ff;
      pair_wr_en   = 1'b0;
      pair_wr_addr = nf_ff[CODE_W-1:0];
      pair_wr_data = {slot_ff, key};
      pair_rd_en   = 1'b0;
      pair_rd_addr = hash_rd_data;

      push_a = 1'b0;
      push_b = 1'b0;
      word_a = '{code: prefix_ff, final_code: 1'b0};
      word_b = '{code: CODE_W'(byte_ff), final_code: 1'b1};

      unique case (state_ff)
         ST_CLEAR: begin
            hash_wr_en   = 1'b1;
            hash_wr_addr = clr_ff;
            hash_wr_data = '0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == {HASH_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               if (!pvalid_ff) begin
                  // stream opens: the byte is the prefix, or the final code if it ends the stream; no lookup
                  if (req_tlast) begin
                     push_a = 1'b1;
                     word_a = '{code: CODE_W'(req_tdata), final_code: 1'b1};
                  end else begin
                     prefix_in = CODE_W'(req_tdata);
                     pvalid_in = 1'b1;
                  end
               end else begin
                  byte_in      = req_tdata;
                  last_in      = req_tlast;
                  slot_in      = hash_key(prefix_ff, req_tdata);
                  hash_rd_en   = 1'b1;
                  hash_rd_addr = hash_key(prefix_ff, req_tdata);
                  state_in     = ST_PROBE;
               end
            end
         end

         ST_PROBE: begin
            if (slot_used) begin
               // confirm the candidate against its stored pair
               cand_in      = hash_rd_data;
               pair_rd_en   = 1'b1;
               pair_rd_addr = hash_rd_data;
               state_in     = ST_VERIFY;
            end else begin
               do_miss = 1'b1;
            end
         end

         ST_VERIFY: begin
            if (pair_rd_slot != slot_ff) begin
               // code was filed under another slot: leftover of an earlier stream
               do_miss = 1'b1;
            end else if (pair_rd_key == key) begin
               // hit: prefix grows to the pair's code, or that code is emitted as final if the byte ends the stream
               if (!last_ff) begin
                  prefix_in = cand_ff;
                  state_in  = ST_IDLE;
               end else if (room != 2'd0) begin
                  push_a    = 1'b1;
                  word_a    = '{code: cand_ff, final_code: 1'b1};
                  prefix_in = '0;
                  pvalid_in = 1'b0;
                  nf_in     = NF_W'(FIRST_FREE_CODE);
                  state_in  = ST_IDLE;
               end
            end else begin
               // collision: advance to the next slot
               slot_in      = slot_ff + 1'b1;
               hash_rd_en   = 1'b1;
               hash_rd_addr = slot_ff + 1'b1;
               state_in     = ST_PROBE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // miss: emit prefix, learn the pair if codes remain, restart from the byte or emit it as final
      if (do_miss && (room >= {1'b0, 1'b1} + {1'b0, last_ff})) begin
         push_a = 1'b1;
         word_a = '{code: prefix_ff, final_code: 1'b0};
         if (table_open) begin
            hash_wr_en = 1'b1;
            pair_wr_en = 1'b1;
            nf_in      = nf_ff + 1'b1;
         end
         prefix_in = CODE_W'(byte_ff);
         if (last_ff) begin
            push_b    = 1'b1;
            word_b    = '{code: CODE_W'(byte_ff), final_code: 1'b1};
            prefix_in = '0;
            pvalid_in = 1'b0;
            nf_in     = NF_W'(FIRST_FREE_CODE);
         end
         state_in = ST_IDLE;
      end
   end

   // two-word output buffer, head in q0
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_ff;
      if (rsp_fire) begin
         q0_in  = q1_ff;
         cnt_in = cnt_ff - 1'b1;
      end
      if (push_a) begin
         if (cnt_in == 2'd0) begin
            q0_in = word_a;
         end else begin
            q1_in = word_a;
         end
         cnt_in = cnt_in + 1'b1;
      end
      if (push_b) begin
         if (cnt_in == 2'd0) begin
            q0_in = word_b;
         end else begin
            q1_in = word_b;
         end
         cnt_in = cnt_in + 1'b1;
      end
   end

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign rsp_tdata  = RSP_W'(q0_ff.code);
   assign rsp_tlast  = q0_ff.final_code;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         prefix_ff <= '0;
         pvalid_ff <= 1'b0;
         nf_ff     <= NF_W'(FIRST_FREE_CODE);
         cnt_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         prefix_ff <= prefix_in;
         pvalid_ff <= pvalid_in;
         nf_ff     <= nf_in;
         cnt_ff    <= cnt_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      slot_ff <= slot_in;
      cand_ff <= cand_in;
      q0_ff   <= q0_in;
      q1_ff   <= q1_in;
   end

endmodule

[rtl/lzw12_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module lzw12_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
